// ----- src/jpc_pkg.sv -----
// Shared types, constants and the arctangent table of the joystick converter.
`default_nettype none
package jpc_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int OFFSET_BITS   = SAMPLE_BITS + 1;
  localparam int DIST_BITS     = 11;
  localparam int RATIO_BITS    = 17;
  localparam int CORDIC_STEPS  = 20;
  localparam int ROOT_STEPS    = 11;
  localparam int DIV_STEPS     = 17;
  localparam int FINISH_STAGE  = ROOT_STEPS;
  localparam int DIV_FIRST     = FINISH_STAGE + 1;
  localparam int NUM_STAGES    = DIV_FIRST + DIV_STEPS + 1;

  // Configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd2;
  localparam logic [1:0] REG_DEAD_ZONE    = 2'd3;

  localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [33:0] HALF_TURN    = 34'sh080000000;
  localparam logic signed [33:0] FULL_TURN    = 34'sh100000000;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE  = 17'h10000;
  localparam logic [RATIO_BITS-1:0] RATIO_HALF = 17'h08000;

  // State carried by every cell of the chain
  typedef struct packed {
    logic signed [OFFSET_BITS-1:0] ox;
    logic signed [OFFSET_BITS-1:0] oy;
    logic                          sw;
    logic                          zero_x;
    logic [20:0]                   sq_rem;
    logic [DIST_BITS-1:0]          root;
    logic signed [33:0]            ca;
    logic signed [33:0]            cb;
    logic signed [33:0]            cz;
    logic [DIST_BITS-1:0]          den;
    logic [27:0]                   drem;
    logic [RATIO_BITS-1:0]         quo;
  } item_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [33:0] atan_of(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41721;
      5'd15: v = 34'sd20860;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2607;
      5'd19: v = 34'sd1303;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/jpc_cordic_cell.sv -----
// One vectoring rotation of the arctangent chain.
`default_nettype none
module jpc_cordic_cell import jpc_pkg::*; (
  input  item_t      item_in,
  input  logic [4:0] step,
  output item_t      item_out
);

  logic signed [33:0] da;
  logic signed [33:0] db;

  // Rotate towards the positive axis, accumulate the angle
  always_comb begin
    da = item_in.cb >>> step;
    db = item_in.ca >>> step;
    item_out = item_in;
    if (!item_in.cb[33]) begin
      item_out.ca = item_in.ca + da;
      item_out.cb = item_in.cb - db;
      item_out.cz = item_in.cz + atan_of(step);
    end else begin
      item_out.ca = item_in.ca - da;
      item_out.cb = item_in.cb + db;
      item_out.cz = item_in.cz - atan_of(step);
    end
  end

endmodule
`default_nettype wire

// ----- src/jpc_root_cell.sv -----
// One result bit of the restoring square root of the squared magnitude.
`default_nettype none
module jpc_root_cell import jpc_pkg::*; (
  input  item_t      item_in,
  input  logic [3:0] bit_idx,
  output item_t      item_out
);

  logic [22:0] cand;

  // Try setting this root bit, keep it when the remainder allows
  always_comb begin
    cand = ({12'b0, item_in.root} << (5'(bit_idx) + 5'd1)) + (23'd1 << {bit_idx, 1'b0});
    item_out = item_in;
    if ({2'b0, item_in.sq_rem} >= cand) begin
      item_out.sq_rem = item_in.sq_rem - cand[20:0];
      item_out.root   = item_in.root | (11'd1 << bit_idx);
    end
  end

endmodule
`default_nettype wire

// ----- src/jpc_div_cell.sv -----
// One quotient bit of the restoring division for the distance ratio.
`default_nettype none
module jpc_div_cell import jpc_pkg::*; (
  input  item_t      item_in,
  input  logic [4:0] step,
  output item_t      item_out
);

  logic [27:0] dsh;

  // Subtract the shifted divisor where it fits
  always_comb begin
    dsh = {17'b0, item_in.den} << step;
    item_out = item_in;
    if (item_in.drem >= dsh) begin
      item_out.drem = item_in.drem - dsh;
      item_out.quo  = item_in.quo | (17'd1 << step);
    end
  end

endmodule
`default_nettype wire

// ----- src/joystick_polar_converter.sv -----
// Top level of the joystick Cartesian-to-polar converter with dead zone.
// Takes one X/Y sample pair per cycle unless the output stalls, and returns
// offsets, distance ratio and angle ratio (17-bit, 65536 = 1.0) through a chain
// of 30 stage registers, whose 29 cell positions carry 20 arctangent rotations
// alongside 11 root bits, one scaling step and 17 divider bits, plus the output
// register. The whole chain holds while the output request is not taken. Write
// configuration only when no request is in flight.
`default_nettype none
module joystick_polar_converter import jpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // raw_x[9:0], raw_y[19:10], switch_level[20], zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // offset_x[10:0], offset_y[21:11],
                                       // distance_ratio[38:22], angle_ratio[55:39],
                                       // switch_state[56], zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  logic [SAMPLE_BITS-1:0] origin_x_r, origin_y_r;
  logic [DIST_BITS-1:0]   max_dist_r, dead_zone_r;

  item_t                  pipe_r [NUM_STAGES];
  logic [NUM_STAGES-1:0]  valid_r;
  item_t                  stage_nxt [NUM_STAGES];

  logic                   adv;
  logic                   out_valid_r;
  logic [63:0]            out_data_r;

  logic signed [OFFSET_BITS-1:0] ox, oy;
  logic signed [21:0]            px, py;
  logic [21:0]                   sq;
  logic signed [33:0]            xs, ys;

  logic signed [33:0]     u;
  logic [32:0]            uc;
  logic [32:0]            ur;
  logic [RATIO_BITS-1:0]  angle;
  logic [RATIO_BITS-1:0]  dist_ratio;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= 10'd512;
      origin_y_r  <= 10'd512;
      max_dist_r  <= 11'd500;
      dead_zone_r <= 11'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:     origin_x_r  <= cfg_data[SAMPLE_BITS-1:0];
        REG_ORIGIN_Y:     origin_y_r  <= cfg_data[SAMPLE_BITS-1:0];
        REG_MAX_DISTANCE: max_dist_r  <= cfg_data;
        REG_DEAD_ZONE:    dead_zone_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Entry: offsets, squared magnitude, quarter-turn pre-rotation
  always_comb begin
    ox = $signed({1'b0, in_tdata[9:0]}) - $signed({1'b0, origin_x_r});
    oy = $signed({1'b0, in_tdata[19:10]}) - $signed({1'b0, origin_y_r});
    px = ox * ox;
    py = oy * oy;
    sq = px + py;
    xs = {{3{ox[10]}}, ox, 20'b0};
    ys = {{3{oy[10]}}, oy, 20'b0};
    stage_nxt[0]        = '0;
    stage_nxt[0].ox     = ox;
    stage_nxt[0].oy     = oy;
    stage_nxt[0].sw     = in_tdata[20];
    stage_nxt[0].zero_x = (ox == '0);
    stage_nxt[0].sq_rem = sq[20:0];
    stage_nxt[0].ca     = ys;
    stage_nxt[0].cb     = xs;
    if (oy[10]) begin
      if (!ox[10]) begin
        stage_nxt[0].ca = xs;
        stage_nxt[0].cb = -ys;
        stage_nxt[0].cz = QUARTER_TURN;
      end else begin
        stage_nxt[0].ca = -xs;
        stage_nxt[0].cb = ys;
        stage_nxt[0].cz = -QUARTER_TURN;
      end
    end
  end

  // Cells between consecutive stage registers
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_cell
    item_t after_c;
    item_t after_r;

    if (k < CORDIC_STEPS) begin : g_cordic
      jpc_cordic_cell u_cordic (
        .item_in  (pipe_r[k]),
        .step     (5'(k)),
        .item_out (after_c)
      );
    end else begin : g_no_cordic
      assign after_c = pipe_r[k];
    end

    if (k < ROOT_STEPS) begin : g_root
      jpc_root_cell u_root (
        .item_in  (after_c),
        .bit_idx  (4'(ROOT_STEPS - 1 - k)),
        .item_out (after_r)
      );
      assign stage_nxt[k+1] = after_r;
    end else if (k == FINISH_STAGE) begin : g_finish
      logic [DIST_BITS:0]   h;
      logic [DIST_BITS-1:0] hc;
      logic [DIST_BITS-1:0] num;
      // Round the root, clamp, remove the dead zone and set up the divider
      always_comb begin
        h   = {1'b0, after_c.root} + 12'(after_c.sq_rem > {10'b0, after_c.root});
        hc  = (h > {1'b0, max_dist_r}) ? max_dist_r : h[DIST_BITS-1:0];
        num = (hc > dead_zone_r) ? hc - dead_zone_r : '0;
        after_r      = after_c;
        after_r.den  = (max_dist_r > dead_zone_r) ? max_dist_r - dead_zone_r : '0;
        after_r.drem = {1'b0, num, 16'b0} + {17'b0, 1'b0, after_r.den[DIST_BITS-1:1]};
        after_r.quo  = '0;
      end
      assign stage_nxt[k+1] = after_r;
    end else begin : g_div
      jpc_div_cell u_div (
        .item_in  (after_c),
        .step     (5'(DIV_STEPS - 1 - (k - DIV_FIRST))),
        .item_out (after_r)
      );
      assign stage_nxt[k+1] = after_r;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        pipe_r[i] <= stage_nxt[i];
      end
    end
  end

  // Map the angle to a ratio, gate the distance for an empty range
  always_comb begin
    u  = pipe_r[NUM_STAGES-1].cz + HALF_TURN;
    if (u[33]) begin
      uc = '0;
    end else if (u > FULL_TURN) begin
      uc = FULL_TURN[32:0];
    end else begin
      uc = u[32:0];
    end
    ur = uc + 33'h8000;
    if (pipe_r[NUM_STAGES-1].zero_x) begin
      angle = pipe_r[NUM_STAGES-1].oy[10] ? RATIO_ONE : RATIO_HALF;
    end else begin
      angle = ur[32:16];
    end
    dist_ratio = (pipe_r[NUM_STAGES-1].den == '0) ? '0 : pipe_r[NUM_STAGES-1].quo;
  end

  // Advance valid flags and the output request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      valid_r     <= {valid_r[NUM_STAGES-2:0], in_tvalid};
      out_valid_r <= valid_r[NUM_STAGES-1];
    end
  end

  // Hold the output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {7'b0, pipe_r[NUM_STAGES-1].sw, angle, dist_ratio,
                     pipe_r[NUM_STAGES-1].oy, pipe_r[NUM_STAGES-1].ox};
    end
  end

endmodule
`default_nettype wire
